### hw/rtl/shs_pkg.sv
// Shared types, codes and the half-step table for the stepper half-step calibrator.
`default_nettype none

package shs_pkg;

  localparam int COUNT_BITS = 16;
  localparam int MOVE_BITS  = 16;
  localparam int ALIGN_BITS = 12;
  localparam int FIELD_BITS = 16;

  typedef enum logic [2:0] {
    FN_TICK       = 3'd0,
    FN_MOVE_CW    = 3'd1,
    FN_MOVE_ACW   = 3'd2,
    FN_OPTICAL    = 3'd3,
    FN_PIEZO      = 3'd4,
    FN_CALIBRATE  = 3'd5,
    FN_CLEAR_PILL = 3'd6
  } func_t;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_MOVE = 2'd1,
    MODE_CAL  = 2'd2
  } mode_t;

  // bit0 drives the first coil
  localparam logic [3:0] HALF_STEP_ROWS [8] = '{
    4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9
  };

  typedef struct packed {
    logic                   fire;
    logic [2:0]             func;
    logic [MOVE_BITS-1:0]   count;
  } step_req_t;

  typedef struct packed {
    logic                   pill_seen;
    logic [FIELD_BITS-1:0]  rev_steps;
    logic [FIELD_BITS-1:0]  steps_per_rev;
    logic                   is_calibrated;
    logic                   busy_res;
    logic [3:0]             coils;
  } step_res_t;

endpackage

`default_nettype wire

### hw/rtl/shs_core.sv
// Sequencer state and next-state logic: phase walk, move runs, calibration, tally.
`default_nettype none

module shs_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic [shs_pkg::ALIGN_BITS-1:0]  cfg_wr_data,
  input  wire shs_pkg::step_req_t              req,
  output shs_pkg::step_res_t                   res
);

  logic [shs_pkg::ALIGN_BITS-1:0] align_r;
  logic [2:0]                     phase_r, phase_nxt;
  logic [3:0]                     coil_r, coil_nxt;
  logic [shs_pkg::MOVE_BITS-1:0]  left_r, left_nxt;
  logic                           acw_r, acw_nxt;
  shs_pkg::mode_t                 mode_r, mode_nxt;
  logic [1:0]                     edges_r, edges_nxt;
  logic [shs_pkg::COUNT_BITS-1:0] tally_r, tally_nxt;
  logic [shs_pkg::COUNT_BITS-1:0] latched_r, latched_nxt;
  logic                           cal_r, cal_nxt;
  logic                           pill_r, pill_nxt;

  shs_pkg::func_t                 func;
  logic                           do_step;
  logic                           step_acw;
  logic [1:0]                     edges_inc;

  assign func      = shs_pkg::func_t'(req.func);
  assign edges_inc = edges_r + 2'd1;

  always_comb begin
    phase_nxt   = phase_r;
    coil_nxt    = coil_r;
    left_nxt    = left_r;
    acw_nxt     = acw_r;
    mode_nxt    = mode_r;
    edges_nxt   = edges_r;
    tally_nxt   = tally_r;
    latched_nxt = latched_r;
    cal_nxt     = cal_r;
    pill_nxt    = pill_r;
    do_step     = 1'b0;
    step_acw    = 1'b0;

    unique case (func) inside
      shs_pkg::FN_TICK: begin
        if (mode_r == shs_pkg::MODE_MOVE) begin
          if (left_r != '0) begin
            do_step  = 1'b1;
            step_acw = acw_r;
            left_nxt = left_r - 1'b1;
          end
          if (left_nxt == '0) begin
            mode_nxt = shs_pkg::MODE_IDLE;
          end
        end else if (mode_r == shs_pkg::MODE_CAL) begin
          do_step = 1'b1;
        end
      end
      shs_pkg::FN_MOVE_CW, shs_pkg::FN_MOVE_ACW: begin
        if (mode_r == shs_pkg::MODE_IDLE) begin
          left_nxt = req.count;
          acw_nxt  = (func == shs_pkg::FN_MOVE_ACW);
          mode_nxt = (req.count != '0) ? shs_pkg::MODE_MOVE : shs_pkg::MODE_IDLE;
        end
      end
      shs_pkg::FN_OPTICAL: begin
        if (!cal_r) begin
          latched_nxt = tally_r;
        end
        tally_nxt = '0;
        if (mode_r == shs_pkg::MODE_CAL) begin
          if (edges_inc >= 2'd2) begin
            // second edge: calibrated, back off by the alignment distance
            cal_nxt   = 1'b1;
            edges_nxt = '0;
            left_nxt  = shs_pkg::MOVE_BITS'(align_r);
            acw_nxt   = 1'b1;
            mode_nxt  = (align_r != '0) ? shs_pkg::MODE_MOVE : shs_pkg::MODE_IDLE;
          end else begin
            edges_nxt = edges_inc;
          end
        end
      end
      shs_pkg::FN_PIEZO: begin
        pill_nxt = 1'b1;
      end
      shs_pkg::FN_CALIBRATE: begin
        if (mode_r == shs_pkg::MODE_IDLE) begin
          cal_nxt   = 1'b0;
          edges_nxt = '0;
          acw_nxt   = 1'b0;
          left_nxt  = '0;
          mode_nxt  = shs_pkg::MODE_CAL;
        end
      end
      shs_pkg::FN_CLEAR_PILL: begin
        pill_nxt = 1'b0;
      end
      default: begin
      end
    endcase

    // drive the current row, then walk the index
    if (do_step) begin
      coil_nxt = shs_pkg::HALF_STEP_ROWS[phase_r];
      if (step_acw) begin
        phase_nxt = phase_r + 3'd1;
      end else begin
        phase_nxt = phase_r - 3'd1;
        if (tally_r != '1) begin
          tally_nxt = tally_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_r <= '0;
    end else if (cfg_wr_en) begin
      align_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      coil_r    <= '0;
      left_r    <= '0;
      acw_r     <= 1'b0;
      mode_r    <= shs_pkg::MODE_IDLE;
      edges_r   <= '0;
      tally_r   <= '0;
      latched_r <= '0;
      cal_r     <= 1'b0;
      pill_r    <= 1'b0;
    end else if (req.fire) begin
      phase_r   <= phase_nxt;
      coil_r    <= coil_nxt;
      left_r    <= left_nxt;
      acw_r     <= acw_nxt;
      mode_r    <= mode_nxt;
      edges_r   <= edges_nxt;
      tally_r   <= tally_nxt;
      latched_r <= latched_nxt;
      cal_r     <= cal_nxt;
      pill_r    <= pill_nxt;
    end
  end

  // result reflects the state after this beat
  assign res.coils         = coil_nxt;
  assign res.busy_res      = (mode_nxt != shs_pkg::MODE_IDLE);
  assign res.is_calibrated = cal_nxt;
  assign res.steps_per_rev = shs_pkg::FIELD_BITS'(latched_nxt);
  assign res.rev_steps     = shs_pkg::FIELD_BITS'(tally_nxt);
  assign res.pill_seen     = pill_nxt;

  a_move_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == shs_pkg::MODE_MOVE) |-> (left_r != '0))
    else $error("move mode with no steps left");

  a_cal_no_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == shs_pkg::MODE_CAL) |-> (left_r == '0 && !cal_r))
    else $error("calibration with queued steps or calibrated flag");

  a_edges_below_two: assert property (@(posedge clk) disable iff (!rst_n)
    !edges_r[1])
    else $error("edge count reached two without completing");

  a_edge_clears_tally: assert property (@(posedge clk) disable iff (!rst_n)
    (req.fire && func == shs_pkg::FN_OPTICAL) |=> (tally_r == '0))
    else $error("optical edge did not clear tally");

endmodule

`default_nettype wire

### hw/rtl/stepper_half_step_calibrator.sv
// Stepper half-step calibrator: input register, sequencer core, output register.
//
// Input stream: in_tuser carries the function code (tick, move cw/acw, optical
// edge, piezo edge, calibrate, clear pill), in_tdata the step count of a move.
// Every input beat yields exactly one output beat with the coil pattern, busy,
// calibrated flag, latched steps per revolution, running tally and pill flag,
// all as they stand after that beat has been applied.
// User must write alignment_steps via cfg_wr_en/cfg_wr_data only while idle; unchecked.
//
// A beat accepted into the input register is applied in the core and registered
// in the output register at the same edge, once the output may advance; out_tvalid rises
// with it. Throughput is one beat per cycle while out_tready does not hold the output.
// When out_tready is low the output register holds its beat and the input
// register may still take one beat; in_tready drops only when both are full.
// Reset (rst_n low, synchronous) clears both registers, the coils (all off),
// counters, flags and alignment_steps.
`default_nettype none

module stepper_half_step_calibrator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] step_count
  input  wire logic [2:0]  in_tuser,   // [2:0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [3:0] coils, [4] busy_res, [5] is_calibrated,
                                       // [21:6] steps_per_rev, [37:22] rev_steps,
                                       // [38] pill_seen, [39] zero
  input  wire logic        cfg_wr_en,
  input  wire logic [11:0] cfg_wr_data
);

  logic                          in_vld_r;
  logic [2:0]                    in_func_r;
  logic [shs_pkg::MOVE_BITS-1:0] in_count_r;
  logic                          out_vld_r;
  shs_pkg::step_res_t            out_res_r;
  logic                          adv;
  shs_pkg::step_req_t            req;
  shs_pkg::step_res_t            res;

  assign adv       = !out_vld_r || out_tready;
  assign in_tready = !in_vld_r || adv;

  assign req.fire  = in_vld_r && adv;
  assign req.func  = in_func_r;
  assign req.count = in_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_func_r  <= in_tuser;
      in_count_r <= in_tdata;
    end
  end

  shs_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .req         (req),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (req.fire) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, out_res_r};

endmodule

`default_nettype wire

### sim/stepper_half_step_calibrator_test.sv
// Self-checking testbench for the stepper half-step calibrator.
module stepper_half_step_calibrator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [2:0] FN_UNUSED = 3'd7;
  localparam logic [shs_pkg::COUNT_BITS-1:0] TALLY_TOP = '1;

  typedef struct {
    logic [2:0]  fn;
    logic [15:0] cnt;
  } beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] step_count
  logic [2:0]  in_tuser = '0;   // [2:0] func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // [3:0] coils, [4] busy_res, [5] is_calibrated,
                                // [21:6] steps_per_rev, [37:22] rev_steps, [38] pill_seen
  logic        cfg_wr_en = 1'b0;
  logic [11:0] cfg_wr_data = '0;

  stepper_half_step_calibrator u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // motor model state
  logic [2:0]                     row_idx;
  logic [3:0]                     coil_q;
  logic [15:0]                    moves_left;
  logic                           acw_dir;
  shs_pkg::mode_t                 run_mode;
  logic [1:0]                     optical_hits;
  logic [shs_pkg::COUNT_BITS-1:0] cw_tally;
  logic [shs_pkg::COUNT_BITS-1:0] rev_latch;
  logic                           calibrated;
  logic                           pill;
  logic [11:0]                    align_cfg;

  beat_t              todo_q[$];
  shs_pkg::step_res_t status_q[$];
  beat_t              nxt;
  shs_pkg::step_res_t got;
  shs_pkg::step_res_t want;
  int                 queued;
  int                 fault_count = 0;
  int                 results_seen = 0;
  int                 cyc = 0;
  int                 hold_left = 0;
  bit                 long_hold_done = 1'b0;
  bit                 quiet = 1'b0;

  function automatic void turn_one(input logic acw);
    coil_q = shs_pkg::HALF_STEP_ROWS[row_idx];
    if (acw) begin
      row_idx = row_idx + 3'd1;
    end else begin
      row_idx = row_idx - 3'd1;
      if (cw_tally != TALLY_TOP) cw_tally = cw_tally + 1'b1;
    end
  endfunction

  function automatic void start_run(input logic [15:0] cnt, input logic acw);
    moves_left = cnt;
    acw_dir = acw;
    run_mode = (cnt != 0) ? shs_pkg::MODE_MOVE : shs_pkg::MODE_IDLE;
  endfunction

  function automatic shs_pkg::step_res_t advance_motor(input logic [2:0] fn,
                                                       input logic [15:0] cnt);
    shs_pkg::step_res_t r;
    case (fn) inside
      shs_pkg::FN_TICK: begin
        if (run_mode == shs_pkg::MODE_MOVE) begin
          if (moves_left != 0) begin
            turn_one(acw_dir);
            moves_left = moves_left - 1'b1;
          end
          if (moves_left == 0) run_mode = shs_pkg::MODE_IDLE;
        end else if (run_mode == shs_pkg::MODE_CAL) begin
          turn_one(1'b0);
        end
      end
      shs_pkg::FN_MOVE_CW, shs_pkg::FN_MOVE_ACW: begin
        if (run_mode == shs_pkg::MODE_IDLE) start_run(cnt, fn == shs_pkg::FN_MOVE_ACW);
      end
      shs_pkg::FN_OPTICAL: begin
        if (!calibrated) rev_latch = cw_tally;
        cw_tally = '0;
        if (run_mode == shs_pkg::MODE_CAL) begin
          optical_hits = optical_hits + 1'b1;
          if (optical_hits >= 2) begin
            calibrated = 1'b1;
            optical_hits = '0;
            start_run(16'(align_cfg), 1'b1);
          end
        end
      end
      shs_pkg::FN_PIEZO: pill = 1'b1;
      shs_pkg::FN_CALIBRATE: begin
        if (run_mode == shs_pkg::MODE_IDLE) begin
          calibrated = 1'b0;
          optical_hits = '0;
          acw_dir = 1'b0;
          moves_left = '0;
          run_mode = shs_pkg::MODE_CAL;
        end
      end
      shs_pkg::FN_CLEAR_PILL: pill = 1'b0;
      default: ;
    endcase
    r.coils = coil_q;
    r.busy_res = (run_mode != shs_pkg::MODE_IDLE);
    r.is_calibrated = calibrated;
    r.steps_per_rev = rev_latch;
    r.rev_steps = cw_tally;
    r.pill_seen = pill;
    return r;
  endfunction

  function automatic void add_beat(input logic [2:0] fn, input logic [15:0] cnt);
    beat_t b;
    b.fn = fn;
    b.cnt = cnt;
    todo_q.push_back(b);
    queued++;
  endfunction

  function automatic void add_ticks(input int n);
    for (int i = 0; i < n; i++) add_beat(shs_pkg::FN_TICK, 16'($urandom));
  endfunction

  // any code, incl. busy commands; moves kept short so an idle block is not tied up
  function automatic void add_noise();
    logic [2:0] fn;
    fn = 3'($urandom_range(7));
    if (fn == shs_pkg::FN_MOVE_CW || fn == shs_pkg::FN_MOVE_ACW)
      add_beat(fn, 16'($urandom_range(15)));
    else add_beat(fn, 16'($urandom));
  endfunction

  function automatic void add_random_run();
    int pick;
    int n;
    pick = $urandom_range(99);
    if (pick < 50) begin
      n = ($urandom_range(9) == 0) ? $urandom_range(200, 40) : $urandom_range(12);
      add_beat($urandom_range(1) ? shs_pkg::FN_MOVE_ACW : shs_pkg::FN_MOVE_CW, 16'(n));
      n = n + $urandom_range(2);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(9) == 0) add_noise();
        add_beat(shs_pkg::FN_TICK, 16'($urandom));
      end
    end else if (pick < 75) begin
      add_beat(shs_pkg::FN_CALIBRATE, 16'($urandom));
      add_ticks($urandom_range(12));
      add_beat(shs_pkg::FN_OPTICAL, 16'($urandom));
      if ($urandom_range(3) == 0) add_noise();
      add_ticks($urandom_range(20));
      add_beat(shs_pkg::FN_OPTICAL, 16'($urandom));
      add_ticks((align_cfg > 60 ? 60 : int'(align_cfg)) + $urandom_range(2));
    end else begin
      add_noise();
    end
  endfunction

  task automatic settle();
    do @(negedge clk);
    while (todo_q.size() != 0 || in_tvalid || status_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic load_alignment(input logic [11:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    align_cfg = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_phase(input int items);
    @(negedge clk);
    queued = 0;
    while (queued < items) add_random_run();
    settle();
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) status_q.push_back(advance_motor(in_tuser, in_tdata));
      if (!in_tvalid || in_tready) begin
        if (todo_q.size() != 0 && (quiet || $urandom_range(99) >= 8)) begin
          nxt = todo_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= nxt.fn;
          in_tdata <= nxt.cnt;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[38:0];
        results_seen <= results_seen + 1;
        if (status_q.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) $display("unexpected status beat %h", out_tdata);
        end else begin
          want = status_q.pop_front();
          if (got.coils !== want.coils || got.busy_res !== want.busy_res ||
              got.is_calibrated !== want.is_calibrated ||
              got.steps_per_rev !== want.steps_per_rev ||
              got.rev_steps !== want.rev_steps || got.pill_seen !== want.pill_seen) begin
            fault_count++;
            if (fault_count <= 10)
              $display({"beat %0d: exp coils %h busy %b cal %b spr %0d rev %0d pill %b,",
                        " got coils %h busy %b cal %b spr %0d rev %0d pill %b"},
                       results_seen, want.coils, want.busy_res, want.is_calibrated,
                       want.steps_per_rev, want.rev_steps, want.pill_seen,
                       got.coils, got.busy_res, got.is_calibrated,
                       got.steps_per_rev, got.rev_steps, got.pill_seen);
          end
        end
      end
      out_tready <= (hold_left == 0) && (quiet || $urandom_range(99) >= 8);
    end
  end

  // long receiver hold-offs; the input side keeps offering and backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (results_seen >= 150 && !long_hold_done) begin
      hold_left <= 80;
      long_hold_done <= 1'b1;
    end else if ($urandom_range(2999) == 0) begin
      hold_left <= $urandom_range(50, 20);
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("stepper_half_step_calibrator_test: FAIL");
      $finish;
    end
  end

  initial begin
    row_idx = '0;
    coil_q = '0;
    moves_left = '0;
    acw_dir = 1'b0;
    run_mode = shs_pkg::MODE_IDLE;
    optical_hits = '0;
    cw_tally = '0;
    rev_latch = '0;
    calibrated = 1'b0;
    pill = 1'b0;
    align_cfg = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    load_alignment(12'd2);
    @(negedge clk);
    add_beat(shs_pkg::FN_TICK, 16'hFFFF);
    add_beat(FN_UNUSED, 16'hFFFF);
    add_beat(shs_pkg::FN_MOVE_CW, 16'd0);
    add_beat(shs_pkg::FN_MOVE_CW, 16'd3);
    add_beat(shs_pkg::FN_MOVE_ACW, 16'd5);
    add_beat(shs_pkg::FN_CALIBRATE, 16'd0);
    add_beat(shs_pkg::FN_PIEZO, 16'd0);
    add_ticks(4);
    add_beat(shs_pkg::FN_OPTICAL, 16'd0);
    add_beat(shs_pkg::FN_MOVE_ACW, 16'd2);
    add_ticks(2);
    add_beat(shs_pkg::FN_CALIBRATE, 16'd0);
    add_ticks(2);
    add_beat(shs_pkg::FN_OPTICAL, 16'd0);
    add_beat(shs_pkg::FN_CLEAR_PILL, 16'd0);
    add_ticks(2);
    add_beat(shs_pkg::FN_OPTICAL, 16'd0);
    add_beat(shs_pkg::FN_CALIBRATE, 16'd0);
    add_ticks(3);
    add_beat(shs_pkg::FN_OPTICAL, 16'd0);
    settle();

    load_alignment(12'd0);
    quiet = 1'b1;
    random_phase(300);
    quiet = 1'b0;

    // long alignment: one full calibration pass
    load_alignment(12'd150);
    @(negedge clk);
    add_beat(shs_pkg::FN_CALIBRATE, 16'($urandom));
    add_ticks(5);
    add_beat(shs_pkg::FN_OPTICAL, 16'($urandom));
    add_ticks(7);
    add_beat(shs_pkg::FN_OPTICAL, 16'($urandom));
    add_ticks(152);
    random_phase(100);

    load_alignment(12'($urandom_range(30, 1)));
    random_phase(400);

    load_alignment(12'($urandom_range(4095)));
    random_phase(200);

    repeat (10) @(negedge clk);
    if (fault_count == 0 && status_q.size() == 0) begin
      $display("stepper_half_step_calibrator_test: PASS");
    end else begin
      $display("stepper_half_step_calibrator_test: FAIL");
    end
    $finish;
  end

endmodule
